// File: rtl/core/dhd_pkg.sv
package dhd_pkg;

	localparam int BOX_ELEMS   = 4;
	localparam int MAX_CLASSES = 255;
	localparam int MAX_ROWS    = 16384;

	localparam int VAL_W   = 16;
	localparam int ROW_W   = 14;
	localparam int CLS_W   = 8;
	localparam int NC_W    = 8;
	localparam int COORD_W = 15;
	localparam int SIZE_W  = 14;
	localparam int CFG_IDX_W = 2;
	// column position reaches BOX_ELEMS + MAX_CLASSES - 1
	localparam int COL_W   = $clog2(BOX_ELEMS + MAX_CLASSES);
	localparam int BOX_IDX_W = $clog2(BOX_ELEMS);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD   = 2'd0,
		CFG_SCALE_X     = 2'd1,
		CFG_SCALE_Y     = 2'd2,
		CFG_NUM_CLASSES = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [VAL_W-1:0] conf_threshold;
		logic [VAL_W-1:0] scale_x;
		logic [VAL_W-1:0] scale_y;
		logic [NC_W-1:0]  class_count;
	} cfg_t;

	// one row that passed the threshold, box still in model coordinates
	typedef struct packed {
		logic [ROW_W-1:0] row_index;
		logic [CLS_W-1:0] best_class;
		logic [VAL_W-1:0] best_score;
		logic [VAL_W-1:0] cx;
		logic [VAL_W-1:0] cy;
		logic [VAL_W-1:0] w;
		logic [VAL_W-1:0] h;
	} cand_t;

endpackage

// File: rtl/core/dhd_if.sv
interface dhd_in_if
	import dhd_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] element_value;
	logic             frame_first;

	modport source(output valid, element_value, frame_first, input ready);
	modport sink(input valid, element_value, frame_first, output ready);
endinterface

interface dhd_out_if
	import dhd_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic [ROW_W-1:0]          row_index;
	logic [CLS_W-1:0]          best_class;
	logic [VAL_W-1:0]          best_score;
	logic signed [COORD_W-1:0] left_x;
	logic signed [COORD_W-1:0] top_y;
	logic [SIZE_W-1:0]         box_width;
	logic [SIZE_W-1:0]         box_height;

	modport source(output valid, row_index, best_class, best_score, left_x, top_y,
		box_width, box_height, input ready);
	modport sink(input valid, row_index, best_class, best_score, left_x, top_y,
		box_width, box_height, output ready);
endinterface

// File: rtl/core/dhd_argmax.sv
module dhd_argmax
	import dhd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	dhd_in_if.sink    elem,
	input  cfg_t      cfg,
	output logic      cand_valid,
	input  logic      cand_ready,
	output cand_t     cand
);

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [VAL_W-1:0] box_q [BOX_ELEMS];
	logic [VAL_W-1:0] max_q;
	logic [CLS_W-1:0] cls_q;
	logic             vld_s1;
	cand_t            cand_s1;

	logic             accept;
	logic [COL_W-1:0] col_eff;
	logic [ROW_W-1:0] row_eff;
	logic [ROW_W-1:0] row_next;
	logic [COL_W-1:0] nc_eff;
	logic [COL_W-1:0] k;
	logic             is_box;
	logic [VAL_W-1:0] cur_max;
	logic [VAL_W-1:0] new_max;
	logic [CLS_W-1:0] new_cls;
	logic             row_end;
	logic             hit;

	assign elem.ready = !vld_s1 || cand_ready;
	assign accept     = elem.valid && elem.ready;

	always_comb begin
		col_eff = elem.frame_first ? '0 : col_q;
		row_eff = elem.frame_first ? '0 : row_q;
		row_next = (row_eff == ROW_W'(MAX_ROWS - 1)) ? '0 : row_eff + 1'b1;
		if (cfg.class_count == '0) begin
			nc_eff = COL_W'(1);
		end else if (COL_W'(cfg.class_count) > COL_W'(MAX_CLASSES)) begin
			nc_eff = COL_W'(MAX_CLASSES);
		end else begin
			nc_eff = COL_W'(cfg.class_count);
		end
		is_box  = col_eff < COL_W'(BOX_ELEMS);
		k       = col_eff - COL_W'(BOX_ELEMS);
		// first score of a row restarts the argmax at zero
		cur_max = (k == '0) ? '0 : max_q;
		if (elem.element_value > cur_max) begin
			new_max = elem.element_value;
			new_cls = k[CLS_W-1:0];
		end else begin
			new_max = cur_max;
			new_cls = (k == '0) ? '0 : cls_q;
		end
		row_end = !is_box && (k + 1'b1 >= nc_eff);
		hit     = row_end && (new_max >= cfg.conf_threshold);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			max_q <= '0;
			cls_q <= '0;
			for (int i = 0; i < BOX_ELEMS; i++) box_q[i] <= '0;
		end else if (accept) begin
			if (is_box) begin
				box_q[col_eff[BOX_IDX_W-1:0]] <= elem.element_value;
				col_q <= col_eff + 1'b1;
				row_q <= row_eff;
			end else begin
				max_q <= new_max;
				cls_q <= new_cls;
				if (row_end) begin
					col_q <= '0;
					row_q <= row_next;
				end else begin
					col_q <= col_eff + 1'b1;
					row_q <= row_eff;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (elem.ready) begin
			vld_s1 <= accept && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hit) begin
			cand_s1.row_index  <= row_eff;
			cand_s1.best_class <= new_cls;
			cand_s1.best_score <= new_max;
			cand_s1.cx         <= box_q[0];
			cand_s1.cy         <= box_q[1];
			cand_s1.w          <= box_q[2];
			cand_s1.h          <= box_q[3];
		end
	end

	assign cand_valid = vld_s1;
	assign cand       = cand_s1;

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_W'(BOX_ELEMS + MAX_CLASSES - 1))
		else $error("column position past last score");

	a_row_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && row_end) |=> (col_q == '0))
		else $error("column not cleared at row end");

	a_cand_held: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !cand_ready) |=> (vld_s1 && $stable(cand_s1)))
		else $error("stalled candidate changed");

endmodule

// File: rtl/core/dhd_box.sv
module dhd_box
	import dhd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cand_valid,
	output logic      cand_ready,
	input  cand_t     cand,
	input  cfg_t      cfg,
	dhd_out_if.source det
);

	localparam int DIFF_W  = VAL_W + 2;
	localparam int PROD_W  = DIFF_W + VAL_W + 1;
	localparam int EXT_W   = 2 * VAL_W;
	localparam int C_SHIFT = 19;
	localparam int E_SHIFT = 18;
	localparam int Q_W     = PROD_W - C_SHIFT;

	logic                     vld_s2;
	logic                     vld_s3;
	logic                     en2;
	logic                     en3;
	logic [ROW_W-1:0]         row_s2;
	logic [CLS_W-1:0]         cls_s2;
	logic [VAL_W-1:0]         score_s2;
	logic signed [PROD_W-1:0] px_s2;
	logic signed [PROD_W-1:0] py_s2;
	logic [EXT_W-1:0]         pw_s2;
	logic [EXT_W-1:0]         ph_s2;
	logic [ROW_W-1:0]         row_s3;
	logic [CLS_W-1:0]         cls_s3;
	logic [VAL_W-1:0]         score_s3;
	logic signed [COORD_W-1:0] lx_s3;
	logic signed [COORD_W-1:0] ty_s3;
	logic [SIZE_W-1:0]        bw_s3;
	logic [SIZE_W-1:0]        bh_s3;

	logic signed [DIFF_W-1:0] dx;
	logic signed [DIFF_W-1:0] dy;

	// shift toward zero, then clamp to the signed output range
	function automatic logic signed [COORD_W-1:0] corner(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] adj;
		logic signed [Q_W-1:0]    q;
		logic signed [Q_W-1:0]    hi;
		logic signed [Q_W-1:0]    lo;
		hi  = Q_W'((1 << (COORD_W - 1)) - 1);
		lo  = -Q_W'(1 << (COORD_W - 1));
		adj = p + (p[PROD_W-1] ? PROD_W'((1 << C_SHIFT) - 1) : '0);
		q   = Q_W'(adj >>> C_SHIFT);
		if (q > hi) begin
			corner = COORD_W'(hi);
		end else if (q < lo) begin
			corner = COORD_W'(lo);
		end else begin
			corner = COORD_W'(q);
		end
	endfunction

	// product is below 2^32, so the shifted value always fits the size range
	function automatic logic [SIZE_W-1:0] extent(input logic [EXT_W-1:0] p);
		extent = p[E_SHIFT +: SIZE_W];
	endfunction

	assign en3        = !vld_s3 || det.ready;
	assign en2        = !vld_s2 || en3;
	assign cand_ready = en2;

	assign dx = $signed({1'b0, cand.cx, 1'b0}) - $signed({2'b00, cand.w});
	assign dy = $signed({1'b0, cand.cy, 1'b0}) - $signed({2'b00, cand.h});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en2) vld_s2 <= cand_valid;
			if (en3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && cand_valid) begin
			row_s2   <= cand.row_index;
			cls_s2   <= cand.best_class;
			score_s2 <= cand.best_score;
			px_s2    <= PROD_W'(dx) * PROD_W'($signed({1'b0, cfg.scale_x}));
			py_s2    <= PROD_W'(dy) * PROD_W'($signed({1'b0, cfg.scale_y}));
			pw_s2    <= EXT_W'(cand.w) * EXT_W'(cfg.scale_x);
			ph_s2    <= EXT_W'(cand.h) * EXT_W'(cfg.scale_y);
		end
		if (en3 && vld_s2) begin
			row_s3   <= row_s2;
			cls_s3   <= cls_s2;
			score_s3 <= score_s2;
			lx_s3    <= corner(px_s2);
			ty_s3    <= corner(py_s2);
			bw_s3    <= extent(pw_s2);
			bh_s3    <= extent(ph_s2);
		end
	end

	assign det.valid      = vld_s3;
	assign det.row_index  = row_s3;
	assign det.best_class = cls_s3;
	assign det.best_score = score_s3;
	assign det.left_x     = lx_s3;
	assign det.top_y      = ty_s3;
	assign det.box_width  = bw_s3;
	assign det.box_height = bh_s3;

	a_s2_held: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !en3) |=> (vld_s2 && $stable(px_s2) && $stable(row_s2)))
		else $error("stalled product stage changed");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && vld_s3 && !det.ready) |=> (vld_s2 && vld_s3))
		else $error("detection lost under stall");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && !det.ready) |=> (vld_s3 && $stable(lx_s3) && $stable(row_s3)))
		else $error("stalled detection changed");

endmodule

// File: rtl/core/detection_head_decode.sv
// a detection is registered as a candidate, then in the box product and output stages
// throughput: one element beat per cycle, set by the running argmax
// the box scaling runs in two registered stages behind it and only holds off input
// once all three stages are full and the output is stalled
// reset: asynchronous, active low; counters, argmax and box fields clear to zero,
// registers return to threshold 16384, scales 4096, 80 classes
module detection_head_decode
	import dhd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	dhd_in_if.sink               elem,
	dhd_out_if.source            det,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]     cfg_data
);

	cfg_t  cfg_q;
	logic  cand_valid;
	logic  cand_ready;
	cand_t cand;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.conf_threshold <= VAL_W'(16384);
			cfg_q.scale_x        <= VAL_W'(4096);
			cfg_q.scale_y        <= VAL_W'(4096);
			cfg_q.class_count    <= NC_W'(80);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_THRESHOLD:   cfg_q.conf_threshold <= cfg_data;
				CFG_SCALE_X:     cfg_q.scale_x        <= cfg_data;
				CFG_SCALE_Y:     cfg_q.scale_y        <= cfg_data;
				CFG_NUM_CLASSES: cfg_q.class_count    <= cfg_data[NC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	dhd_argmax u_argmax (
		.clk        (clk),
		.arst_n     (arst_n),
		.elem       (elem),
		.cfg        (cfg_q),
		.cand_valid (cand_valid),
		.cand_ready (cand_ready),
		.cand       (cand)
	);

	dhd_box u_box (
		.clk        (clk),
		.arst_n     (arst_n),
		.cand_valid (cand_valid),
		.cand_ready (cand_ready),
		.cand       (cand),
		.cfg        (cfg_q),
		.det        (det)
	);

endmodule
